/* rtl/sca_pkg.sv */
// Shared types, constants and helper functions for the sector chain allocator.
// Used by the link memory, the command sequencer and the top level.
package sca_pkg;

  localparam int ENTRIES     = 4096;
  localparam int SECTOR_BITS = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int LINK_W      = $clog2(ENTRIES + 1);
  localparam int CNT_W       = 13;
  localparam int POS_W       = 12;
  localparam int KIND_W      = 4;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 32;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  typedef logic [LINK_W-1:0]      link_t;
  typedef logic [SECTOR_BITS-1:0] sect_t;

  localparam link_t END_MARK = LINK_W'(ENTRIES);

  typedef enum logic [KIND_W-1:0] {
    K_FORMAT    = 4'd0,
    K_ALLOC     = 4'd1,
    K_RELEASE   = 4'd2,
    K_NEXT      = 4'd3,
    K_APPEND    = 4'd4,
    K_NTH       = 4'd5,
    K_LAST      = 4'd6,
    K_PRED      = 4'd7,
    K_TERMINATE = 4'd8
  } kind_t;

  typedef enum logic {
    REG_DATA_BASE  = 1'b0,
    REG_DATA_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    sect_t base;
    link_t n;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    sect_t             sector;
    sect_t             chain_head;
    logic              head_present;
    logic [POS_W-1:0]  position;
  } op_t;

  typedef struct packed {
    sect_t             found;
    logic              ok;
    logic [CNT_W-1:0]  free_left;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    link_t             wdata;
    logic [IDX_W-1:0]  raddr;
  } link_req_t;

  function automatic link_t eff_count(input logic [CNT_W-1:0] dc);
    if (32'(dc) > 32'(ENTRIES)) begin
      return END_MARK;
    end
    return LINK_W'(dc);
  endfunction

  function automatic link_t to_rel(input sect_t s, input cfg_t c);
    sect_t r;
    r = s - c.base;
    if (32'(r) < 32'(c.n)) begin
      return LINK_W'(r);
    end
    return END_MARK;
  endfunction

  function automatic sect_t to_abs(input link_t rel, input cfg_t c);
    return c.base + SECTOR_BITS'(rel);
  endfunction

endpackage

/* rtl/sca_link_ram.sv */
// Link table memory: one next-pointer per data sector.
// One write port and one read port with registered read data; uses sca_pkg.
module sca_link_ram import sca_pkg::*; (
  input  logic      clk,
  input  link_req_t req,
  output link_t     rdata
);

  link_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* rtl/sca_seq.sv */
// Command sequencer: runs one command at a time over the link memory.
// Holds the free-list head and count; depends on sca_pkg only.
module sca_seq import sca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      op_valid,
  input  op_t       op,
  output logic      op_ready,
  output logic      res_valid,
  input  logic      res_take,
  output res_t      res,
  output link_req_t ram_req,
  input  link_t     ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_FMT, S_RD, S_EV, S_WR, S_WR2, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  link_t             srel_r, srel_nxt;
  link_t             cur_r, cur_nxt;
  link_t             cnt_r, cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  link_t             fh_r, fh_nxt;
  link_t             ft_r, ft_nxt;
  sect_t             found_r, found_nxt;
  logic              ok_r, ok_nxt;
  logic [IDX_W-1:0]  wa_r, wa_nxt;
  link_t             wd_r, wd_nxt;

  logic [31:0] step;
  link_t       nx;
  link_t       fh_eff;
  link_t       srel_in;
  link_t       head_in;

  always_comb begin
    step    = 32'(cnt_r) + 32'd1;
    nx      = (32'(ram_rdata) < 32'(cfg.n)) ? ram_rdata : END_MARK;
    fh_eff  = (32'(fh_r) >= 32'(cfg.n)) ? END_MARK : fh_r;
    srel_in = to_rel(op.sector, cfg);
    head_in = op.head_present ? to_rel(op.chain_head, cfg) : END_MARK;

    state_nxt = state_r;
    kind_nxt  = kind_r;
    srel_nxt  = srel_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    fh_nxt    = fh_r;
    ft_nxt    = ft_r;
    found_nxt = found_r;
    ok_nxt    = ok_r;
    wa_nxt    = wa_r;
    wd_nxt    = wd_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = wa_r;
    ram_req.wdata = wd_r;
    ram_req.raddr = cur_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (op_valid) begin
          kind_nxt  = op.kind;
          srel_nxt  = srel_in;
          pos_nxt   = op.position;
          cnt_nxt   = '0;
          fh_nxt    = fh_eff;
          found_nxt = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
          case (op.kind)
            K_FORMAT: begin
              ok_nxt = 1'b1;
              ft_nxt = cfg.n;
              if (cfg.n != '0) begin
                fh_nxt    = '0;
                state_nxt = S_FMT;
              end else begin
                fh_nxt = END_MARK;
              end
            end
            K_ALLOC: begin
              if (fh_eff != END_MARK) begin
                cur_nxt   = fh_eff;
                state_nxt = S_RD;
              end
            end
            K_RELEASE: begin
              if (srel_in != END_MARK) begin
                wa_nxt = srel_in[IDX_W-1:0];
                wd_nxt = fh_eff;
                fh_nxt = srel_in;
                if (32'(ft_r) < 32'(cfg.n)) begin
                  ft_nxt = ft_r + link_t'(1);
                end
                ok_nxt    = 1'b1;
                state_nxt = S_WR;
              end
            end
            K_TERMINATE: begin
              if (srel_in != END_MARK) begin
                wa_nxt    = srel_in[IDX_W-1:0];
                wd_nxt    = END_MARK;
                ok_nxt    = 1'b1;
                state_nxt = S_WR;
              end
            end
            K_NEXT: begin
              if (srel_in != END_MARK) begin
                cur_nxt   = srel_in;
                state_nxt = S_RD;
              end
            end
            K_APPEND: begin
              if (head_in != END_MARK && srel_in != END_MARK) begin
                cur_nxt   = head_in;
                state_nxt = S_RD;
              end
            end
            K_NTH: begin
              if (head_in != END_MARK && 32'(op.position) < 32'(ENTRIES)) begin
                cur_nxt = head_in;
                if (op.position == '0) begin
                  found_nxt = to_abs(head_in, cfg);
                  ok_nxt    = 1'b1;
                end else begin
                  state_nxt = S_RD;
                end
              end
            end
            K_LAST: begin
              if (head_in != END_MARK) begin
                cur_nxt   = head_in;
                state_nxt = S_RD;
              end
            end
            K_PRED: begin
              if (head_in != END_MARK && srel_in != END_MARK && head_in != srel_in) begin
                cur_nxt   = head_in;
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_FMT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r[IDX_W-1:0];
        ram_req.wdata = (step < 32'(cfg.n)) ? LINK_W'(step) : END_MARK;
        cnt_nxt       = LINK_W'(step);
        if (step >= 32'(cfg.n)) begin
          state_nxt = S_FIN;
        end
      end

      S_RD: begin
        state_nxt = S_EV;
      end

      S_EV: begin
        cnt_nxt   = LINK_W'(step);
        state_nxt = S_FIN;
        case (kind_r)
          K_ALLOC: begin
            fh_nxt = nx;
            if (ft_r != '0) begin
              ft_nxt = ft_r - link_t'(1);
            end
            wa_nxt    = cur_r[IDX_W-1:0];
            wd_nxt    = END_MARK;
            found_nxt = to_abs(cur_r, cfg);
            ok_nxt    = 1'b1;
            state_nxt = S_WR;
          end
          K_NEXT: begin
            if (nx != END_MARK) begin
              found_nxt = to_abs(nx, cfg);
              ok_nxt    = 1'b1;
            end
          end
          K_LAST, K_APPEND: begin
            if (nx == END_MARK) begin
              ok_nxt = 1'b1;
              if (kind_r == K_APPEND) begin
                wa_nxt    = cur_r[IDX_W-1:0];
                wd_nxt    = srel_r;
                state_nxt = S_WR;
              end else begin
                found_nxt = to_abs(cur_r, cfg);
              end
            end else if (step < 32'(ENTRIES)) begin
              cur_nxt   = nx;
              state_nxt = S_RD;
            end
          end
          K_NTH: begin
            if (nx != END_MARK) begin
              if (step == 32'(pos_r)) begin
                found_nxt = to_abs(nx, cfg);
                ok_nxt    = 1'b1;
              end else begin
                cur_nxt   = nx;
                state_nxt = S_RD;
              end
            end
          end
          K_PRED: begin
            if (nx != END_MARK && step < 32'(ENTRIES)) begin
              if (nx == srel_r) begin
                found_nxt = to_abs(cur_r, cfg);
                ok_nxt    = 1'b1;
              end else begin
                cur_nxt   = nx;
                state_nxt = S_RD;
              end
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_WR: begin
        ram_req.we = 1'b1;
        state_nxt  = (kind_r == K_APPEND) ? S_WR2 : S_FIN;
      end

      S_WR2: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = srel_r[IDX_W-1:0];
        ram_req.wdata = END_MARK;
        state_nxt     = S_FIN;
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fh_r    <= END_MARK;
      ft_r    <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fh_r    <= fh_nxt;
      ft_r    <= ft_nxt;
      ok_r    <= ok_nxt;
    end
    kind_r  <= kind_nxt;
    srel_r  <= srel_nxt;
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    wa_r    <= wa_nxt;
    wd_r    <= wd_nxt;
  end

  assign op_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_FIN);
  assign res.found     = found_r;
  assign res.ok        = ok_r;
  assign res.free_left = CNT_W'(ft_r);

endmodule

/* rtl/sector_chain_allocator.sv */
// Top level of the sector chain allocator: stream ports, APB registers and
// the result register. Depends on sca_pkg, sca_seq and sca_link_ram.
//
// Usage: a command beat on the in_ channel carries a kind in in_tuser and
// its operands in in_tdata. Each command returns exactly one beat on the out_
// channel with the found sector, a success flag and the free count.
// The user must write the data base and data count registers over the APB
// port only while the block is idle; the block itself does not enforce this.
// Commands run one at a time; in_tready is low from the accepting edge until
// the result has moved into the output register.
// Steps: a successful release or terminate does one link write, next one
// link read, alloc one read and one write, format one write per managed
// sector, and a chain walk one read per link; a successful append adds its
// two writes. A command that fails its range checks goes straight to the
// result. The link memory's single read port sets the walk rate: one read
// and one compare per link.
// A format must precede other commands after reset, since the link table is
// not cleared; reset empties the free list and zeroes the APB registers.
// When the receiver stalls, the result waits in the output register and the
// next command can be accepted and run until its own result is ready.
module sector_chain_allocator import sca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] sector, [31:16] chain_head, [32] head_present, [44:33] position
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [3:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] found_sector, [16] ok, [29:17] free_left
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_AW-1:0]     cfg_paddr,
  input  logic [APB_DW-1:0]     cfg_pwdata,
  output logic [APB_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  sect_t             base_r;
  logic [CNT_W-1:0]  dcount_r;
  logic              cfg_wr;
  cfg_t              cfg;
  op_t               op;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r;
  logic              res_valid;
  logic              res_take;
  link_req_t         ram_req;
  link_t             ram_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      dcount_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[2]))
        REG_DATA_BASE:  base_r   <= cfg_pwdata[SECTOR_BITS-1:0];
        REG_DATA_COUNT: dcount_r <= cfg_pwdata[CNT_W-1:0];
        default:        base_r   <= base_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[2]))
      REG_DATA_BASE:  cfg_prdata = APB_DW'(base_r);
      REG_DATA_COUNT: cfg_prdata = APB_DW'(dcount_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.base = base_r;
  assign cfg.n    = eff_count(dcount_r);

  assign op.kind         = kind_t'(in_tuser);
  assign op.sector       = in_tdata[15:0];
  assign op.chain_head   = in_tdata[31:16];
  assign op.head_present = in_tdata[32];
  assign op.position     = in_tdata[44:33];

  sca_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .op_valid  (in_tvalid),
    .op        (op),
    .op_ready  (in_tready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  sca_link_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign res_take = res_valid & (~out_valid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_take | (out_valid_r & ~out_tready);
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.free_left, out_res_r.ok, out_res_r.found};

  a_fail_no_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.ok |-> out_res_r.found == '0)
    else $error("failed result carries a sector");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> 32'(out_res_r.free_left) <= 32'(ENTRIES))
    else $error("free count above table size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command accepted while one is running");

endmodule
